FILE: design/bbcw_pkg.sv
// Shared constants, types and codes of the box blur block.
`default_nettype none

package bbcw_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_RADIUS_DEF = 8;
    localparam int PIXEL_BITS_DEF = 8;

    localparam int WIDTH_CFG_W  = 12;
    localparam int HEIGHT_CFG_W = 13;
    localparam int RADIUS_CFG_W = 4;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int RADIUS_RESET = 8;

    localparam int HEIGHT_LIMIT = 4096;
    localparam int FRAC_BITS    = 8;
    localparam int MEAN_W       = 16;
    localparam int QUEUE_DEPTH  = 4;

    // descriptor field widths, sized for the top of each parameter range
    localparam int PIX_FW  = 16;
    localparam int COL_FW  = 13;
    localparam int ROW_FW  = 13;
    localparam int SLOT_FW = 7;
    localparam int WIN_FW  = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS       = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;

    typedef struct packed {
        logic [PIX_FW-1:0]  val;
        logic               wr_en;
        logic [SLOT_FW-1:0] wr_slot;
        logic [COL_FW-1:0]  wr_col;
        logic               has_out;
        logic [SLOT_FW-1:0] rd_slot;
        logic [COL_FW-1:0]  rd_col;
        logic [WIN_FW-1:0]  rows_m1;
        logic [WIN_FW-1:0]  cols_m1;
        logic               last;
    } blur_desc_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_WRITE,
        BK_READ,
        BK_DRAIN,
        BK_PREP,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

FILE: design/bbcw_if.sv
// Valid/ready channel interfaces for pixel items and mean items.
`default_nettype none

interface bbcw_in_if #(
    parameter int PIXEL_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output cmd, output pixel, input ready);
    modport sink (input valid, input cmd, input pixel, output ready);
endinterface

interface bbcw_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] mean_value;
    logic        frame_last;

    modport source (output valid, output mean_value, output frame_last, input ready);
    modport sink (input valid, input mean_value, input frame_last, output ready);
endinterface

`default_nettype wire

FILE: design/bbcw_queue.sv
// Short descriptor queue between the front and back parts.
`default_nettype none

module bbcw_queue
    import bbcw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  blur_desc_t      push_data,
    input  wire logic       pop,
    output blur_desc_t      pop_data,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    blur_desc_t         slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/bbcw_front.sv
// Front part: configuration, stream position tracking and window classification.
`default_nettype none

module bbcw_front
    import bbcw_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    bbcw_in_if.sink                     pix_in,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   q_full,
    output logic                        q_push,
    output blur_desc_t                  q_data
);

    // one row for every row that can lie between the window top and the input row
    localparam int NR        = 3 * MAX_RADIUS + 1;
    localparam int SLOT_BITS = $clog2(NR);
    localparam int CW        = $clog2(MAX_WIDTH + 1);
    localparam int RDW       = $clog2(MAX_RADIUS + 1);
    localparam int CSW       = CW + RDW;
    localparam int RW        = ROW_FW;
    localparam int POS_W     = $clog2(HEIGHT_LIMIT * MAX_WIDTH + MAX_RADIUS * MAX_WIDTH
                                      + MAX_RADIUS + 1);

    logic [WIDTH_CFG_W-1:0]  width_reg;
    logic [HEIGHT_CFG_W-1:0] height_reg;
    logic [RADIUS_CFG_W-1:0] radius_reg;

    logic [RW-1:0]        in_row_reg, in_row_next;
    logic [CW-1:0]        in_col_reg, in_col_next;
    logic [RW-1:0]        out_row_reg, out_row_next;
    logic [CW-1:0]        out_col_reg, out_col_next;
    logic [SLOT_BITS-1:0] in_slot_reg, in_slot_next;
    logic [POS_W-1:0]     pos_reg, pos_next;

    logic [CW-1:0]        wd;
    logic [RW-1:0]        ht;
    logic [RDW-1:0]       rd;
    logic                 accept, is_image, due, last, clear;
    logic [RW-1:0]        r0, r1, rsum, row_dist;
    logic [CW-1:0]        c0, c1;
    logic [CSW-1:0]       csum;
    logic [CSW-1:0]       lag_prod;
    logic [POS_W-1:0]     lag;
    logic [SLOT_BITS-1:0] dslot, rd_slot;
    logic [SLOT_BITS:0]   slot_wrap;

    assign pix_in.ready = !q_full;
    assign accept       = pix_in.valid && !q_full;
    assign q_push       = accept;

    // saturated geometry
    always_comb
    begin
        if (width_reg == '0)
            wd = CW'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            wd = CW'(MAX_WIDTH);
        else
            wd = CW'(width_reg);

        if (height_reg == '0)
            ht = RW'(1);
        else if (int'(height_reg) > HEIGHT_LIMIT)
            ht = RW'(HEIGHT_LIMIT);
        else
            ht = RW'(height_reg);

        if (int'(radius_reg) > MAX_RADIUS)
            rd = RDW'(MAX_RADIUS);
        else
            rd = RDW'(radius_reg);
    end

    // output starts once the input is radius rows plus radius items ahead
    assign lag_prod = CSW'(wd) * CSW'(rd);
    assign lag      = POS_W'(lag_prod) + POS_W'(rd);
    assign is_image = in_row_reg < ht;
    assign due      = pos_reg >= lag;
    assign last     = due && (out_row_reg == ht - 1'b1) && (out_col_reg == wd - 1'b1);

    // clipped window bounds
    always_comb
    begin
        r0   = (out_row_reg > rd) ? out_row_reg - RW'(rd) : '0;
        rsum = out_row_reg + RW'(rd);
        r1   = (rsum < ht) ? rsum : ht - 1'b1;
        c0   = (out_col_reg > rd) ? out_col_reg - CW'(rd) : '0;
        csum = CSW'(out_col_reg) + CSW'(rd);
        c1   = (csum < CSW'(wd)) ? CW'(csum) : wd - 1'b1;
    end

    // ring slot of the top window row; the distance is below NR while output is due
    always_comb
    begin
        row_dist  = in_row_reg - r0;
        dslot     = SLOT_BITS'(row_dist);
        slot_wrap = (SLOT_BITS + 1)'(in_slot_reg) + (SLOT_BITS + 1)'(NR)
                    - (SLOT_BITS + 1)'(dslot);
        rd_slot   = (in_slot_reg >= dslot) ? in_slot_reg - dslot : SLOT_BITS'(slot_wrap);
    end

    always_comb
    begin
        q_data.val     = (is_image && (pix_in.cmd == CMD_PIXEL)) ? PIX_FW'(pix_in.pixel) : '0;
        q_data.wr_en   = is_image;
        q_data.wr_slot = SLOT_FW'(in_slot_reg);
        q_data.wr_col  = COL_FW'(in_col_reg);
        q_data.has_out = due;
        q_data.rd_slot = SLOT_FW'(rd_slot);
        q_data.rd_col  = COL_FW'(c0);
        q_data.rows_m1 = WIN_FW'(r1 - r0);
        q_data.cols_m1 = WIN_FW'(c1 - c0);
        q_data.last    = last;
    end

    always_comb
    begin
        clear = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_RADIUS: clear = 1'b1;
                default:                                       clear = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        in_slot_next = in_slot_reg;
        pos_next     = pos_reg;
        if (clear || (accept && last))
        begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
            in_slot_next = '0;
            pos_next     = '0;
        end
        else if (accept)
        begin
            pos_next = pos_reg + 1'b1;
            if (in_col_reg == wd - 1'b1)
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + 1'b1;
                in_slot_next = (in_slot_reg == SLOT_BITS'(NR - 1)) ? '0 : in_slot_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
            if (due)
            begin
                if (out_col_reg == wd - 1'b1)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_CFG_W'(WIDTH_RESET);
            height_reg  <= HEIGHT_CFG_W'(HEIGHT_RESET);
            radius_reg  <= RADIUS_CFG_W'(RADIUS_RESET);
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            in_slot_reg <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_CFG_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_CFG_W-1:0];
                    REG_RADIUS:       radius_reg <= cfg_data[RADIUS_CFG_W-1:0];
                    default:          ;
                endcase
            end
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            in_slot_reg <= in_slot_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/bbcw_back.sv
// Back part: row store, window accumulation, rounding divider and result register.
`default_nettype none

module bbcw_back
    import bbcw_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    q_empty,
    input  blur_desc_t   q_data,
    output logic         q_pop,
    bbcw_out_if.source   mean_out
);

    localparam int NR        = 3 * MAX_RADIUS + 1;
    localparam int SLOT_BITS = $clog2(NR);
    localparam int COL_A     = $clog2(MAX_WIDTH);
    localparam int ADDR_W    = SLOT_BITS + COL_A;
    localparam int MEM_DEPTH = NR << COL_A;
    localparam int WIN       = 2 * MAX_RADIUS + 1;
    localparam int WIN_W     = $clog2(WIN + 1);
    localparam int CNT_W     = 2 * WIN_W;
    localparam int SUM_W     = PIXEL_BITS + $clog2(WIN * WIN);
    localparam int NUM_W     = SUM_W + FRAC_BITS + 1;
    localparam int ITER_W    = $clog2(NUM_W);
    localparam int PROD_W    = 2 * (WIN_FW + 1);

    back_state_t          state_reg, state_next;
    blur_desc_t           desc_reg;
    logic [SLOT_BITS-1:0] cur_slot_reg;
    logic [COL_A-1:0]     cur_col_reg;
    logic [WIN_FW-1:0]    row_left_reg, col_left_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [CNT_W-1:0]     cnt_reg, rem_reg, rem_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [ITER_W-1:0]    iter_reg;
    logic                 rd_pend_reg;
    logic                 out_valid_reg;
    logic [MEAN_W-1:0]    mean_reg;
    logic                 last_reg;

    logic [PIXEL_BITS-1:0] pix_mem [MEM_DEPTH];
    logic [PIXEL_BITS-1:0] rdata_reg;

    logic                 mem_we, rd_issue, last_issue, load_out;
    logic [ADDR_W-1:0]    waddr, raddr;
    logic [PROD_W-1:0]    win_prod;
    logic [CNT_W:0]       rem_sh;
    logic                 ge;
    logic [MEAN_W-1:0]    mean_sat;

    assign waddr = {desc_reg.wr_slot[SLOT_BITS-1:0], desc_reg.wr_col[COL_A-1:0]};
    assign raddr = {cur_slot_reg, cur_col_reg};

    assign win_prod = PROD_W'(({1'b0, desc_reg.rows_m1} + 1'b1))
                    * PROD_W'(({1'b0, desc_reg.cols_m1} + 1'b1));

    // restoring division, one quotient bit per cycle, quotient shifts into num_reg
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign ge       = rem_sh >= {1'b0, cnt_reg};
    assign rem_next = ge ? CNT_W'(rem_sh - {1'b0, cnt_reg}) : CNT_W'(rem_sh);
    assign num_next = {num_reg[NUM_W-2:0], ge};
    assign mean_sat = (|num_reg[NUM_W-1:MEAN_W]) ? '1 : num_reg[MEAN_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:  if (!q_empty) state_next = BK_WRITE;
            BK_WRITE: state_next = desc_reg.has_out ? BK_READ : BK_IDLE;
            BK_READ:  if (last_issue) state_next = BK_DRAIN;
            BK_DRAIN: state_next = BK_PREP;
            BK_PREP:  state_next = BK_DIV;
            BK_DIV:   if (iter_reg == ITER_W'(NUM_W - 1)) state_next = BK_DONE;
            BK_DONE:  if (load_out) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop      = (state_reg == BK_IDLE) && !q_empty;
        mem_we     = (state_reg == BK_WRITE) && desc_reg.wr_en;
        rd_issue   = (state_reg == BK_READ);
        last_issue = rd_issue && (row_left_reg == '0) && (col_left_reg == '0);
        load_out   = (state_reg == BK_DONE) && (!out_valid_reg || mean_out.ready);
    end

    assign mean_out.valid      = out_valid_reg;
    assign mean_out.mean_value = mean_reg;
    assign mean_out.frame_last = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_issue;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (mean_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            desc_reg <= q_data;
        end
        case (state_reg)
            BK_WRITE:
            begin
                cur_slot_reg <= desc_reg.rd_slot[SLOT_BITS-1:0];
                cur_col_reg  <= desc_reg.rd_col[COL_A-1:0];
                row_left_reg <= desc_reg.rows_m1;
                col_left_reg <= desc_reg.cols_m1;
                sum_reg      <= '0;
                cnt_reg      <= CNT_W'(win_prod);
            end
            BK_READ:
            begin
                if (col_left_reg == '0)
                begin
                    col_left_reg <= desc_reg.cols_m1;
                    cur_col_reg  <= desc_reg.rd_col[COL_A-1:0];
                    row_left_reg <= row_left_reg - 1'b1;
                    cur_slot_reg <= (cur_slot_reg == SLOT_BITS'(NR - 1)) ? '0
                                    : cur_slot_reg + 1'b1;
                end
                else
                begin
                    col_left_reg <= col_left_reg - 1'b1;
                    cur_col_reg  <= cur_col_reg + 1'b1;
                end
            end
            BK_PREP:
            begin
                num_reg  <= NUM_W'({sum_reg, {FRAC_BITS{1'b0}}}) + NUM_W'(cnt_reg >> 1);
                rem_reg  <= '0;
                iter_reg <= '0;
            end
            BK_DIV:
            begin
                num_reg  <= num_next;
                rem_reg  <= rem_next;
                iter_reg <= iter_reg + 1'b1;
            end
            default: ;
        endcase
        // read data lands in the cycle after its address
        if (rd_pend_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(rdata_reg);
        end
        if (load_out)
        begin
            mean_reg <= mean_sat;
            last_reg <= desc_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pix_mem[waddr] <= desc_reg.val[PIXEL_BITS-1:0];
        end
        rdata_reg <= pix_mem[raddr];
    end

    a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_PREP |-> cnt_reg != '0)
        else $error("window count is zero at divide start");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_DIV |-> rem_reg < cnt_reg)
        else $error("divider remainder out of range");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_READ |-> int'(cur_slot_reg) < NR)
        else $error("ring slot beyond row store");

    a_drain_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_DRAIN |-> rd_pend_reg && $past(last_issue))
        else $error("last window read not pending at drain");

endmodule

`default_nettype wire

FILE: design/box_blur_clamped_window_unit.sv
// An item with no result leaves the queue and is retired through the write state; an item with
// a result then reads the row store once per window pixel, drains, prepares and runs a 1-bit/cycle
// divider over a numerator of NUM_W bits (26 by default), then waits in the done state for the output.
// The back part works on one item at a time; the front keeps accepting items until the queue is full.
// Reset: counters clear, registers load 640 x 480 with radius 8; row store contents are not cleared.
`default_nettype none

module box_blur_clamped_window_unit
    import bbcw_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    bbcw_in_if.sink                     pix_in,
    bbcw_out_if.source                  mean_out,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    blur_desc_t push_data, pop_data;
    logic       q_push, q_pop, q_full, q_empty;

    bbcw_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    bbcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    bbcw_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (pop_data),
        .q_pop    (q_pop),
        .mean_out (mean_out)
    );

endmodule

`default_nettype wire
